// ===== rtl/mame_pkg.sv =====
// Shared types and constants of the matrix add and multiply engine.
package mame_pkg;

  localparam int unsigned DIM_W  = 4;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 6;

  localparam logic [1:0] OP_LOAD_A = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_SUM    = 2'd2;
  localparam logic [1:0] OP_PROD   = 2'd3;

  localparam logic [1:0] REG_A_ROWS = 2'd0;
  localparam logic [1:0] REG_A_COLS = 2'd1;
  localparam logic [1:0] REG_B_ROWS = 2'd2;
  localparam logic [1:0] REG_B_COLS = 2'd3;

  typedef enum logic [2:0] {
    CMD_LOAD_A,
    CMD_LOAD_B,
    CMD_SUM,
    CMD_PROD,
    CMD_ERR
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ERR,
    ST_RUN,
    ST_WAIT
  } st_e;

  typedef struct packed {
    logic [1:0]              operation;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic signed [DATA_W-1:0] element_value;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [DATA_W-1:0] out_value;
    logic                    status;
    logic                    last;
  } res_t;

  typedef struct packed {
    logic [DIM_W-1:0] a_rows;
    logic [DIM_W-1:0] a_cols;
    logic [DIM_W-1:0] b_rows;
    logic [DIM_W-1:0] b_cols;
  } cfg_t;

  typedef struct packed {
    cmd_e              kind;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] value;
    logic [DIM_W-1:0]  n_rows;
    logic [DIM_W-1:0]  n_cols;
    logic [DIM_W-1:0]  n_inner;
  } cmd_t;

endpackage

// ===== rtl/mame_ram.sv =====
// Generic single write port RAM with one registered read port.
module mame_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mame_fifo.sv =====
// Small first-in first-out queue built from registers.
module mame_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             rd_en_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PW = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d;
  logic [PW-1:0]    rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_en_i && !full_o;
  assign do_rd   = rd_en_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (do_rd) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/mame_front.sv =====
// Front end: accepts requests, classifies them and queues commands for the back end.
module mame_front #(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  mame_pkg::req_t req_i,
  input  mame_pkg::cfg_t cfg_i,
  input  logic           cmd_pop_i,
  output logic           cmd_empty_o,
  output mame_pkg::cmd_t cmd_o
);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned CMD_W  = $bits(mame_pkg::cmd_t);

  mame_pkg::cmd_t           cmd;
  logic                     keep;
  logic                     pos_ok;
  logic [CMD_W-1:0]         qdata;

  function automatic logic dim_ok(input logic [mame_pkg::DIM_W-1:0] d);
    return (d != '0) && (d <= mame_pkg::DIM_W'(MAX_DIM));
  endfunction

  assign pos_ok = ({1'b0, req_i.row_index} < mame_pkg::DIM_W'(MAX_DIM)) &&
                  ({1'b0, req_i.col_index} < mame_pkg::DIM_W'(MAX_DIM));

  always_comb begin
    cmd.addr    = mame_pkg::ADDR_W'(req_i.row_index) * mame_pkg::ADDR_W'(MAX_DIM) +
                  mame_pkg::ADDR_W'(req_i.col_index);
    cmd.value   = req_i.element_value;
    cmd.n_rows  = cfg_i.a_rows;
    cmd.n_cols  = cfg_i.a_cols;
    cmd.n_inner = mame_pkg::DIM_W'(1);
    cmd.kind    = mame_pkg::CMD_ERR;
    keep        = 1'b1;
    case (req_i.operation)
      mame_pkg::OP_LOAD_A: begin
        cmd.kind = mame_pkg::CMD_LOAD_A;
        keep     = pos_ok;
      end
      mame_pkg::OP_LOAD_B: begin
        cmd.kind = mame_pkg::CMD_LOAD_B;
        keep     = pos_ok;
      end
      mame_pkg::OP_SUM: begin
        if (dim_ok(cfg_i.a_rows) && dim_ok(cfg_i.a_cols) &&
            cfg_i.a_rows == cfg_i.b_rows && cfg_i.a_cols == cfg_i.b_cols) begin
          cmd.kind = mame_pkg::CMD_SUM;
        end
      end
      mame_pkg::OP_PROD: begin
        cmd.n_cols  = cfg_i.b_cols;
        cmd.n_inner = cfg_i.a_cols;
        if (dim_ok(cfg_i.a_rows) && dim_ok(cfg_i.a_cols) && dim_ok(cfg_i.b_cols) &&
            cfg_i.a_cols == cfg_i.b_rows) begin
          cmd.kind = mame_pkg::CMD_PROD;
        end
      end
      default: begin
        cmd.kind = mame_pkg::CMD_ERR;
      end
    endcase
  end

  mame_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (QDEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (push_i && keep),
    .wdata_i (cmd),
    .rd_en_i (cmd_pop_i),
    .rdata_o (qdata),
    .full_o  (full_o),
    .empty_o (cmd_empty_o)
  );

  assign cmd_o = mame_pkg::cmd_t'(qdata);

endmodule

// ===== rtl/mame_back.sv =====
// Back end: owns the matrix stores and walks the sum or product sequence.
module mame_back #(
  parameter int unsigned MAX_DIM     = 8,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_empty_i,
  input  mame_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  input  logic           res_full_i,
  output logic           res_push_o,
  output mame_pkg::res_t res_o
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int unsigned IW    = MAX_DIM > 1 ? $clog2(MAX_DIM) : 1;
  localparam int unsigned DW    = mame_pkg::DATA_W;
  localparam int unsigned PW    = 2 * DW;
  localparam int unsigned ACC_W = PW + 3;
  localparam int unsigned VW    = VALUE_WIDTH < 16 ? 16 : (VALUE_WIDTH > DW ? DW : VALUE_WIDTH);
  localparam logic signed [ACC_W-1:0] VMAX = ACC_W'((longint'(1) << (VW - 1)) - 1);
  localparam logic signed [ACC_W-1:0] VMIN = ~VMAX;

  mame_pkg::st_e               state_q, state_d;
  logic                        is_prod_q;
  logic [mame_pkg::DIM_W-1:0]  rows_q, cols_q, inner_q;
  logic [IW-1:0]               i_q, i_d, j_q, j_d, k_q, k_d;
  logic                        start, issue;
  logic                        k_last, j_last, i_last;
  logic                        s1_vld_q, s1_first_q, s1_last_q;
  logic                        s2_vld_q, s2_first_q, s2_last_q;
  logic signed [PW-1:0]        term_q;
  logic signed [ACC_W-1:0]     acc_q;
  logic                        done_q;
  logic                        wr_a, wr_b;
  logic [AW-1:0]               raddr_a, raddr_b;
  logic [DW-1:0]               rd_a, rd_b;
  logic signed [PW-1:0]        mul_w, add_w;
  logic signed [ACC_W-1:0]     scaled;
  logic signed [DW-1:0]        sat_val;

  function automatic logic [AW-1:0] idx(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(r) * AW'(MAX_DIM) + AW'(c);
  endfunction

  assign k_last = (mame_pkg::DIM_W'(k_q) + mame_pkg::DIM_W'(1)) == inner_q;
  assign j_last = (mame_pkg::DIM_W'(j_q) + mame_pkg::DIM_W'(1)) == cols_q;
  assign i_last = (mame_pkg::DIM_W'(i_q) + mame_pkg::DIM_W'(1)) == rows_q;

  assign raddr_a = is_prod_q ? idx(i_q, k_q) : idx(i_q, j_q);
  assign raddr_b = is_prod_q ? idx(k_q, j_q) : idx(i_q, j_q);

  mame_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_store_a (
    .clk_i   (clk_i),
    .we_i    (wr_a),
    .waddr_i (cmd_i.addr[AW-1:0]),
    .wdata_i (cmd_i.value),
    .raddr_i (raddr_a),
    .rdata_o (rd_a)
  );

  mame_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_store_b (
    .clk_i   (clk_i),
    .we_i    (wr_b),
    .waddr_i (cmd_i.addr[AW-1:0]),
    .wdata_i (cmd_i.value),
    .raddr_i (raddr_b),
    .rdata_o (rd_b)
  );

  // The sum is the same walk with a single term per element and no scaling.
  assign mul_w = $signed(rd_a) * $signed(rd_b);
  assign add_w = PW'($signed(rd_a)) + PW'($signed(rd_b));

  // Products: flooring shift of the Q32.32 sum back to Q16.16; sums are not shifted. Then clamp.
  assign scaled  = is_prod_q ? (acc_q >>> 16) : acc_q;
  assign sat_val = (scaled > VMAX) ? DW'(VMAX) : ((scaled < VMIN) ? DW'(VMIN) : DW'(scaled));

  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    start      = 1'b0;
    issue      = 1'b0;
    wr_a       = 1'b0;
    wr_b       = 1'b0;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    case (state_q)
      mame_pkg::ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.kind)
            mame_pkg::CMD_LOAD_A: begin
              wr_a = 1'b1;
            end
            mame_pkg::CMD_LOAD_B: begin
              wr_b = 1'b1;
            end
            mame_pkg::CMD_SUM, mame_pkg::CMD_PROD: begin
              start   = 1'b1;
              i_d     = '0;
              j_d     = '0;
              k_d     = '0;
              state_d = mame_pkg::ST_RUN;
            end
            default: begin
              state_d = mame_pkg::ST_ERR;
            end
          endcase
        end
      end
      mame_pkg::ST_ERR: begin
        if (!res_full_i) begin
          res_push_o   = 1'b1;
          res_o.status = 1'b1;
          res_o.last   = 1'b1;
          state_d      = mame_pkg::ST_IDLE;
        end
      end
      mame_pkg::ST_RUN: begin
        issue = 1'b1;
        if (k_last) begin
          k_d     = '0;
          state_d = mame_pkg::ST_WAIT;
        end else begin
          k_d = k_q + IW'(1);
        end
      end
      mame_pkg::ST_WAIT: begin
        if (done_q && !res_full_i) begin
          res_push_o      = 1'b1;
          res_o.out_row   = mame_pkg::IDX_W'(i_q);
          res_o.out_col   = mame_pkg::IDX_W'(j_q);
          res_o.out_value = sat_val;
          res_o.last      = i_last && j_last;
          if (j_last) begin
            j_d = '0;
            i_d = i_q + IW'(1);
          end else begin
            j_d = j_q + IW'(1);
          end
          state_d = (i_last && j_last) ? mame_pkg::ST_IDLE : mame_pkg::ST_RUN;
        end
      end
      default: begin
        state_d = mame_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mame_pkg::ST_IDLE;
      i_q        <= '0;
      j_q        <= '0;
      k_q        <= '0;
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      i_q      <= i_d;
      j_q      <= j_d;
      k_q      <= k_d;
      s1_vld_q <= issue;
      s2_vld_q <= s1_vld_q;
      if (s2_vld_q && s2_last_q) begin
        done_q <= 1'b1;
      end else if (res_push_o) begin
        done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      is_prod_q <= (cmd_i.kind == mame_pkg::CMD_PROD);
      rows_q    <= cmd_i.n_rows;
      cols_q    <= cmd_i.n_cols;
      inner_q   <= cmd_i.n_inner;
    end
    s1_first_q <= (k_q == '0);
    s1_last_q  <= k_last;
    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    if (s1_vld_q) begin
      term_q <= is_prod_q ? mul_w : add_w;
    end
    if (s2_vld_q) begin
      acc_q <= (s2_first_q ? '0 : acc_q) + ACC_W'(term_q);
    end
  end

endmodule

// ===== rtl/matrix_add_multiply_engine_unit.sv =====
// Top level of the matrix add and multiply engine with its configuration registers.
//
// The engine holds two square stores of MAX_DIM x MAX_DIM signed Q16.16
// elements, A and B. Requests arrive through a queue-style port (push/full):
// operation 0 or 1 loads one element of A or B at row_index/col_index, while
// operation 2 adds A and B element by element and operation 3 forms the
// product A*B, using the dimensions held in the four configuration registers
// (a_rows, a_cols, b_rows, b_cols at byte addresses 0, 4, 8 and 12). Results
// leave through a second queue-style port (empty/pop) in row-major order, and
// the final element of a command carries last. Products are summed at full
// Q32.32 precision, shifted down with rounding toward minus infinity, and every
// result is saturated to a VALUE_WIDTH-bit signed value (taken between 16 and
// 32 bits). A command whose dimensions are zero, larger than MAX_DIM or do not
// fit the operation yields a single result with status set, last set and all
// other fields zero. A front end accepts one request per cycle, unless full,
// into a four-entry command queue while a back end carries the commands out in
// order; a two-entry result queue lets the back end keep working while the
// consumer stalls. The back end writes each load into its store from the idle
// state. The stores have one read port each, so one multiply-accumulate term
// enters the read, multiply and accumulate pipeline per cycle, and the
// sequencer waits for the accumulator to settle before it starts the next
// element. Reading an element that was never loaded since reset returns an
// unspecified value.
// Configuration may only be changed while the engine is idle.
module matrix_add_multiply_engine_unit #(
  parameter int unsigned MAX_DIM     = 8,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  // Request queue side.
  input  logic           push,
  output logic           full,
  input  mame_pkg::req_t req_i,
  // Result queue side.
  output logic           empty,
  input  logic           pop,
  output mame_pkg::res_t res_o,
  // Configuration port.
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  localparam int unsigned RES_W = $bits(mame_pkg::res_t);

  mame_pkg::cfg_t cfg_q;
  logic           cfg_wr;
  logic [1:0]     reg_sel;
  logic           cmd_pop, cmd_empty;
  mame_pkg::cmd_t cmd;
  logic           res_push, res_full;
  mame_pkg::res_t res;
  logic [RES_W-1:0] res_data;

  // Register file: one 4-bit dimension per word, the rest of the word reads zero.
  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        mame_pkg::REG_A_ROWS: cfg_q.a_rows <= pwdata[mame_pkg::DIM_W-1:0];
        mame_pkg::REG_A_COLS: cfg_q.a_cols <= pwdata[mame_pkg::DIM_W-1:0];
        mame_pkg::REG_B_ROWS: cfg_q.b_rows <= pwdata[mame_pkg::DIM_W-1:0];
        mame_pkg::REG_B_COLS: cfg_q.b_cols <= pwdata[mame_pkg::DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      mame_pkg::REG_A_ROWS: prdata = 32'(cfg_q.a_rows);
      mame_pkg::REG_A_COLS: prdata = 32'(cfg_q.a_cols);
      mame_pkg::REG_B_ROWS: prdata = 32'(cfg_q.b_rows);
      mame_pkg::REG_B_COLS: prdata = 32'(cfg_q.b_cols);
      default:              prdata = '0;
    endcase
  end

  // The front end classifies each request and queues it as a command.
  mame_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .req_i       (req_i),
    .cfg_i       (cfg_q),
    .cmd_pop_i   (cmd_pop),
    .cmd_empty_o (cmd_empty),
    .cmd_o       (cmd)
  );

  // The back end owns both stores and produces the result elements.
  mame_back #(
    .MAX_DIM     (MAX_DIM),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  // The result queue separates the back end from a stalling consumer.
  mame_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (res_push),
    .wdata_i (res),
    .rd_en_i (pop),
    .rdata_o (res_data),
    .full_o  (res_full),
    .empty_o (empty)
  );

  assign res_o = mame_pkg::res_t'(res_data);

endmodule
